@@ design/shift_latch_channel_driver_core_defines.svh @@
// assertion macros used by the checker file
`ifndef SHIFT_LATCH_CHANNEL_DRIVER_CORE_DEFINES_SVH
`define SHIFT_LATCH_CHANNEL_DRIVER_CORE_DEFINES_SVH

// clocked property, off while reset is high
`define SLCD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked through reset as well
`define SLCD_ASSERT_RST(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/slcd_pkg.sv @@
package slcd_pkg;

   // default parameter values
   localparam int CHANNELS_DEF        = 8;
   localparam int MASK_BITS_DEF       = 16;
   localparam int INIT_IDLE_TICKS_DEF = 100;

   // fixed field widths
   localparam int LATCH_W    = 8;
   localparam int MASK_W     = 16;
   localparam int TICK_W     = 20;
   localparam int CFG_DATA_W = 20;
   localparam int CFG_IDX_W  = 3;

   // actions
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_INIT  = 2'd1;
   localparam logic [1:0] ACT_APPLY = 2'd2;
   localparam logic [1:0] ACT_FORCE = 2'd3;

   // error codes
   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_NOT_READY = 3'd1;
   localparam logic [2:0] ERR_SAFE      = 3'd2;
   localparam logic [2:0] ERR_CHANNEL   = 3'd3;
   localparam logic [2:0] ERR_BUSY      = 3'd4;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HALF  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_DATA_SETUP  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_LATCH_SETUP = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_LATCH_PULSE = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_PULSE = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_BREAK_MAKE  = 3'd5;

   typedef enum logic [4:0] {
      PH_IDLE, PH_INIT_IDLE, PH_CLR_HI1, PH_CLR_LO, PH_CLR_HI2,
      PH_L_SETUP, PH_S_CLKLOW, PH_S_DATA, PH_CK_LO, PH_CK_HI, PH_CK_LO2,
      PH_S_DATA_END, PH_L_PRE, PH_L_LOW, PH_L_HIGH, PH_L_LOW2, PH_BREAK
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NONE, KIND_INIT, KIND_APPLY_OFF, KIND_APPLY_ON, KIND_FORCE
   } kind_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  channel;
      logic [15:0] mask;
      logic        safe_state_active;
   } req_type;

   typedef struct packed {
      logic        serial_data;
      logic        shift_clock;
      logic        clear_n;
      logic [7:0]  latch_lines;
      logic        busy_res;
      logic        done_res;
      logic [2:0]  error_code;
      logic        outputs_safe;
      logic [15:0] readback_mask;
      logic [31:0] readback_count;
   } rsp_type;

   typedef struct packed {
      logic [7:0]        clock_half;
      logic [7:0]        data_setup;
      logic [7:0]        latch_setup;
      logic [7:0]        latch_pulse;
      logic [7:0]        clear_pulse;
      logic [TICK_W-1:0] break_make;
   } cfg_type;

   typedef struct packed {
      logic               data;
      logic               clk;
      logic               clr;
      logic [LATCH_W-1:0] latch;
   } pins_type;

   localparam pins_type PINS_IDLE = '{data: 1'b0, clk: 1'b0, clr: 1'b1, latch: '0};

   // write into the per-channel record
   typedef struct packed {
      logic              en;
      logic [2:0]        chan;
      logic [MASK_W-1:0] mask;
      logic              count_inc;
   } rec_wr_type;

   // status of one tick
   typedef struct packed {
      pins_type   pins;
      logic       busy;
      logic       done;
      logic [2:0] err;
      logic       safe;
   } step_type;

   // segment length minus one, a zero count taken as one tick
   function automatic logic [TICK_W-1:0] ticks_m1(input logic [TICK_W-1:0] v);
      return (v == '0) ? '0 : v - 1'b1;
   endfunction

endpackage

@@ design/shift_latch_channel_driver_core.sv @@
// response: registered, shown in the cycle after its request tick is accepted
// throughput: one tick per cycle; a request is taken while the response
//   register is empty or being drained in the same cycle
// reset: synchronous, active high; sequencer idle with clear_n high and the
//   other pins low, ready and safe flags low, channel records zero
module shift_latch_channel_driver_core
   import slcd_pkg::*;
#(
   parameter int CHANNELS        = CHANNELS_DEF,
   parameter int MASK_BITS       = MASK_BITS_DEF,
   parameter int INIT_IDLE_TICKS = INIT_IDLE_TICKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg_ff;
   rec_wr_type        rec_wr;
   step_type          step;
   logic              accept;
   logic [MASK_W-1:0] rd_mask;
   logic [31:0]       rd_count;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_half  <= 8'd1;
         cfg_ff.data_setup  <= 8'd1;
         cfg_ff.latch_setup <= 8'd1;
         cfg_ff.latch_pulse <= 8'd1;
         cfg_ff.clear_pulse <= 8'd1;
         cfg_ff.break_make  <= TICK_W'(1000);
      end else if (csr_we) begin
         case (csr_index)
            CFG_CLOCK_HALF:  cfg_ff.clock_half  <= csr_wdata[7:0];
            CFG_DATA_SETUP:  cfg_ff.data_setup  <= csr_wdata[7:0];
            CFG_LATCH_SETUP: cfg_ff.latch_setup <= csr_wdata[7:0];
            CFG_LATCH_PULSE: cfg_ff.latch_pulse <= csr_wdata[7:0];
            CFG_CLEAR_PULSE: cfg_ff.clear_pulse <= csr_wdata[7:0];
            CFG_BREAK_MAKE:  cfg_ff.break_make  <= csr_wdata[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   slcd_sequencer #(
      .CHANNELS        (CHANNELS),
      .MASK_BITS       (MASK_BITS),
      .INIT_IDLE_TICKS (INIT_IDLE_TICKS)
   ) u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept),
      .item    (req_data),
      .cfg     (cfg_ff),
      .rec_wr  (rec_wr),
      .step    (step)
   );

   slcd_record #(
      .CHANNELS (CHANNELS)
   ) u_record (
      .clock      (clock),
      .reset      (reset),
      .step_en    (accept),
      .rec_wr     (rec_wr),
      .rd_channel (req_data.channel),
      .rd_mask    (rd_mask),
      .rd_count   (rd_count)
   );

   // response contents
   always_comb begin
      rsp_data_in.serial_data    = step.pins.data;
      rsp_data_in.shift_clock    = step.pins.clk;
      rsp_data_in.clear_n        = step.pins.clr;
      rsp_data_in.latch_lines    = step.pins.latch;
      rsp_data_in.busy_res       = step.busy;
      rsp_data_in.done_res       = step.done;
      rsp_data_in.error_code     = step.err;
      rsp_data_in.outputs_safe   = step.safe;
      rsp_data_in.readback_mask  = rd_mask;
      rsp_data_in.readback_count = rd_count;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/slcd_sequencer.sv @@
module slcd_sequencer
   import slcd_pkg::*;
#(
   parameter int CHANNELS        = CHANNELS_DEF,
   parameter int MASK_BITS       = MASK_BITS_DEF,
   parameter int INIT_IDLE_TICKS = INIT_IDLE_TICKS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  req_type    item,
   input  cfg_type    cfg,
   output rec_wr_type rec_wr,
   output step_type   step
);

   phase_type         phase_ff, phase_in;
   kind_type          kind_ff, kind_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [4:0]        bit_ff, bit_in;
   logic [2:0]        chan_ff, chan_in;
   logic [MASK_W-1:0] work_ff, work_in;
   logic [MASK_W-1:0] pend_ff, pend_in;
   logic              ready_ff, ready_in;
   logic              safe_ff, safe_in;
   pins_type          pins_ff, pins_in;

   logic              enter_en;
   phase_type         enter_ph;
   logic              finish;
   logic [2:0]        err;
   logic [4:0]        bit_next;
   logic [3:0]        chan_next;

   assign bit_next  = bit_ff + 5'd1;
   assign chan_next = {1'b0, chan_ff} + 4'd1;

   // one tick of the pin sequencer
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      chan_in  = chan_ff;
      work_in  = work_ff;
      pend_in  = pend_ff;
      ready_in = ready_ff;
      safe_in  = safe_ff;
      pins_in  = pins_ff;
      enter_en = 1'b0;
      enter_ph = PH_IDLE;
      finish   = 1'b0;
      err      = ERR_OK;
      rec_wr   = '0;

      if (phase_ff != PH_IDLE) begin
         if (item.action != ACT_TICK) begin
            err = ERR_BUSY;
         end
         if (tick_ff != '0) begin
            tick_in = tick_ff - 1'b1;
         end else begin
            // segment over, move on
            case (phase_ff)
               PH_INIT_IDLE: begin
                  enter_en = 1'b1; enter_ph = PH_CLR_HI1;
               end
               PH_CLR_HI1: begin
                  enter_en = 1'b1; enter_ph = PH_CLR_LO;
               end
               PH_CLR_LO: begin
                  enter_en = 1'b1; enter_ph = PH_CLR_HI2;
               end
               PH_CLR_HI2: begin
                  if (kind_ff == KIND_FORCE) begin
                     chan_in  = '0;
                     work_in  = '0;
                     enter_en = 1'b1; enter_ph = PH_L_SETUP;
                  end else begin
                     ready_in = 1'b1;
                     finish   = 1'b1;
                  end
               end
               PH_L_SETUP: begin
                  enter_en = 1'b1; enter_ph = PH_S_CLKLOW;
               end
               PH_S_CLKLOW: begin
                  bit_in   = '0;
                  enter_en = 1'b1; enter_ph = PH_S_DATA;
               end
               PH_S_DATA: begin
                  enter_en = 1'b1; enter_ph = PH_CK_LO;
               end
               PH_CK_LO: begin
                  enter_en = 1'b1; enter_ph = PH_CK_HI;
               end
               PH_CK_HI: begin
                  enter_en = 1'b1; enter_ph = PH_CK_LO2;
               end
               PH_CK_LO2: begin
                  bit_in   = bit_next;
                  enter_en = 1'b1;
                  enter_ph = (bit_next < 5'(MASK_BITS)) ? PH_S_DATA : PH_S_DATA_END;
               end
               PH_S_DATA_END: begin
                  enter_en = 1'b1; enter_ph = PH_L_PRE;
               end
               PH_L_PRE: begin
                  enter_en = 1'b1; enter_ph = PH_L_LOW;
               end
               PH_L_LOW: begin
                  enter_en = 1'b1; enter_ph = PH_L_HIGH;
               end
               PH_L_HIGH: begin
                  enter_en = 1'b1; enter_ph = PH_L_LOW2;
               end
               PH_L_LOW2: begin
                  // latch finished: record the mask, then pick what follows
                  rec_wr.en   = 1'b1;
                  rec_wr.chan = chan_ff;
                  rec_wr.mask = work_ff;
                  if (kind_ff == KIND_APPLY_OFF) begin
                     if (cfg.break_make != '0) begin
                        enter_en = 1'b1; enter_ph = PH_BREAK;
                     end else begin
                        kind_in  = KIND_APPLY_ON;
                        work_in  = pend_ff;
                        enter_en = 1'b1; enter_ph = PH_L_SETUP;
                     end
                  end else if (kind_ff == KIND_APPLY_ON) begin
                     rec_wr.count_inc = 1'b1;
                     safe_in = 1'b1;
                     finish  = 1'b1;
                  end else if (kind_ff == KIND_FORCE && chan_next < 4'(CHANNELS)) begin
                     chan_in  = chan_next[2:0];
                     work_in  = '0;
                     enter_en = 1'b1; enter_ph = PH_L_SETUP;
                  end else begin
                     safe_in = 1'b1;
                     finish  = 1'b1;
                  end
               end
               PH_BREAK: begin
                  kind_in  = KIND_APPLY_ON;
                  work_in  = pend_ff;
                  enter_en = 1'b1; enter_ph = PH_L_SETUP;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
      end else begin
         // idle: start a command
         case (item.action)
            ACT_INIT: begin
               kind_in  = KIND_INIT;
               enter_en = 1'b1; enter_ph = PH_INIT_IDLE;
            end
            ACT_APPLY: begin
               if (!ready_ff) begin
                  err = ERR_NOT_READY;
               end else if (item.safe_state_active) begin
                  err = ERR_SAFE;
               end else if (item.channel >= 8'(CHANNELS)) begin
                  err = ERR_CHANNEL;
               end else begin
                  safe_in  = 1'b0;
                  kind_in  = KIND_APPLY_OFF;
                  pend_in  = item.mask;
                  chan_in  = item.channel[2:0];
                  work_in  = '0;
                  enter_en = 1'b1; enter_ph = PH_L_SETUP;
               end
            end
            ACT_FORCE: begin
               safe_in = 1'b0;
               if (!ready_ff) begin
                  err = ERR_NOT_READY;
               end else begin
                  kind_in      = KIND_FORCE;
                  pins_in.data = 1'b0;
                  pins_in.clk  = 1'b0;
                  enter_en = 1'b1; enter_ph = PH_CLR_HI1;
               end
            end
            default: begin
            end
         endcase
      end

      // sequence end: pins back to rest
      if (finish) begin
         phase_in = PH_IDLE;
         kind_in  = KIND_NONE;
         tick_in  = '0;
         pins_in  = PINS_IDLE;
      end

      // segment entry: pin change and segment length
      if (enter_en) begin
         phase_in = enter_ph;
         case (enter_ph)
            PH_INIT_IDLE: begin
               pins_in = PINS_IDLE;
               tick_in = TICK_W'(INIT_IDLE_TICKS - 1);
            end
            PH_CLR_HI1, PH_CLR_HI2: begin
               pins_in.clr = 1'b1;
               tick_in = ticks_m1(TICK_W'(cfg.clear_pulse));
            end
            PH_CLR_LO: begin
               pins_in.clr = 1'b0;
               tick_in = ticks_m1(TICK_W'(cfg.clear_pulse));
            end
            PH_L_SETUP: begin
               pins_in.data           = 1'b0;
               pins_in.clk            = 1'b0;
               pins_in.latch[chan_in] = 1'b0;
               tick_in = ticks_m1(TICK_W'(cfg.latch_setup));
            end
            PH_S_CLKLOW, PH_CK_LO, PH_CK_LO2: begin
               pins_in.clk = 1'b0;
               tick_in = ticks_m1(TICK_W'(cfg.clock_half));
            end
            PH_CK_HI: begin
               pins_in.clk = 1'b1;
               tick_in = ticks_m1(TICK_W'(cfg.clock_half));
            end
            PH_S_DATA: begin
               pins_in.data = work_in[bit_in[3:0]];
               tick_in = ticks_m1(TICK_W'(cfg.data_setup));
            end
            PH_S_DATA_END: begin
               pins_in.data = 1'b0;
               tick_in = ticks_m1(TICK_W'(cfg.data_setup));
            end
            PH_L_PRE: begin
               tick_in = ticks_m1(TICK_W'(cfg.latch_setup));
            end
            PH_L_LOW, PH_L_LOW2: begin
               pins_in.latch[chan_in] = 1'b0;
               tick_in = ticks_m1(TICK_W'(cfg.latch_setup));
            end
            PH_L_HIGH: begin
               pins_in.latch[chan_in] = 1'b1;
               tick_in = ticks_m1(TICK_W'(cfg.latch_pulse));
            end
            PH_BREAK: begin
               tick_in = ticks_m1(cfg.break_make);
            end
            default: begin
               tick_in = '0;
            end
         endcase
      end
   end

   // status of this tick
   always_comb begin
      step.pins = pins_in;
      step.busy = (phase_in != PH_IDLE);
      step.done = finish;
      step.err  = err;
      step.safe = safe_in;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= KIND_NONE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         chan_ff  <= '0;
         work_ff  <= '0;
         pend_ff  <= '0;
         ready_ff <= 1'b0;
         safe_ff  <= 1'b0;
         pins_ff  <= PINS_IDLE;
      end else if (step_en) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         chan_ff  <= chan_in;
         work_ff  <= work_in;
         pend_ff  <= pend_in;
         ready_ff <= ready_in;
         safe_ff  <= safe_in;
         pins_ff  <= pins_in;
      end
   end

endmodule

@@ design/slcd_record.sv @@
module slcd_record
   import slcd_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  rec_wr_type        rec_wr,
   input  logic [7:0]        rd_channel,
   output logic [MASK_W-1:0] rd_mask,
   output logic [31:0]       rd_count
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [MASK_W-1:0] masks_ff [CHANNELS];
   logic [31:0]       counts_ff [CHANNELS];

   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rd_idx;
   logic              rd_ok;
   logic              wr_hit;
   logic [31:0]       count_new;

   assign wr_idx    = rec_wr.chan[IDX_W-1:0];
   assign rd_idx    = rd_channel[IDX_W-1:0];
   assign rd_ok     = rd_channel < 8'(CHANNELS);
   assign wr_hit    = rec_wr.en && (wr_idx == rd_idx);
   assign count_new = counts_ff[wr_idx] + 32'd1;

   // readback sees the write of the same tick
   always_comb begin
      rd_mask  = '0;
      rd_count = '0;
      if (rd_ok) begin
         rd_mask  = wr_hit ? rec_wr.mask : masks_ff[rd_idx];
         rd_count = (wr_hit && rec_wr.count_inc) ? count_new : counts_ff[rd_idx];
      end
   end

   // per-channel mask and apply count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            masks_ff[i]  <= '0;
            counts_ff[i] <= '0;
         end
      end else if (step_en && rec_wr.en) begin
         masks_ff[wr_idx] <= rec_wr.mask;
         if (rec_wr.count_inc) begin
            counts_ff[wr_idx] <= count_new;
         end
      end
   end

endmodule

@@ design/slcd_checker.sv @@
`include "shift_latch_channel_driver_core_defines.svh"

module slcd_checker
   import slcd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled response holds
   `SLCD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled response changed")

   // requests are refused only while a response is stalled
   `SLCD_ASSERT(a_ready_only_full, clock, reset, !req_ready |-> rsp_valid && !rsp_ready, "request refused with room")

   // no running sequence means pins at rest
   `SLCD_ASSERT(a_idle_pins, clock, reset, rsp_valid && !rsp_data.busy_res |-> !rsp_data.serial_data && !rsp_data.shift_clock && rsp_data.clear_n && rsp_data.latch_lines == '0, "pins not at rest while idle")

   // a busy rejection only happens while a sequence runs or ends
   `SLCD_ASSERT(a_busy_err, clock, reset, rsp_valid && rsp_data.error_code == ERR_BUSY |-> rsp_data.busy_res || rsp_data.done_res, "busy error while idle")

   // reset empties the response register
   `SLCD_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind shift_latch_channel_driver_core slcd_checker u_slcd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/sv/shift_latch_channel_driver_core_test.sv @@
`timescale 1ns / 1ps

module shift_latch_channel_driver_core_test;
   import slcd_pkg::*;

   // register indexes that the block has no register for
   localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

   // one queued tick with the response it should produce
   typedef struct {
      req_type req;
      rsp_type rsp;
   } tick_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CFG_IDX_W-1:0]  csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_wdata = '0;

   shift_latch_channel_driver_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ticks waiting to be driven, and responses owed for accepted ticks
   tick_item_type queued_ticks [$];
   rsp_type       pin_forecast [$];
   tick_item_type next_item;
   rsp_type       held_forecast;
   rsp_type       want;

   // 0 none, 1 sender idle 75%, 2 receiver stall 75%, 3 both 21%
   int idle_mode = 0;

   int failures = 0;
   int rsp_count = 0;
   int ticks_sent = 0;
   int seq_started = 0;
   int turned_away = 0;
   int reg_writes = 0;
   int settings_used = 0;

   // sequencer mirror: timing registers and state
   cfg_type timing = '{clock_half: 8'd1, data_setup: 8'd1, latch_setup: 8'd1,
                       latch_pulse: 8'd1, clear_pulse: 8'd1, break_make: 20'd1000};
   phase_type         seq_phase = PH_IDLE;
   kind_type          seq_kind = KIND_NONE;
   logic [TICK_W-1:0] ticks_left = '0;
   int                shift_bit = 0;
   logic [2:0]        latch_chan = '0;
   logic [MASK_W-1:0] shift_mask = '0;
   logic [MASK_W-1:0] next_mask = '0;
   logic              is_ready = 1'b0;
   logic              is_safe = 1'b0;
   logic              seq_done = 1'b0;
   logic [MASK_W-1:0] chan_mask [CHANNELS_DEF] = '{default: '0};
   logic [31:0]       chan_count [CHANNELS_DEF] = '{default: '0};
   pins_type          pins = PINS_IDLE;

   // enter a segment, set its pins and its length
   function automatic void enter_seg(phase_type p);
      logic [TICK_W-1:0] dur;
      dur = TICK_W'(1);
      seq_phase = p;
      case (p)
         PH_INIT_IDLE: begin
            pins = PINS_IDLE;
            dur = TICK_W'(INIT_IDLE_TICKS_DEF);
         end
         PH_CLR_HI1, PH_CLR_HI2: begin
            pins.clr = 1'b1;
            dur = TICK_W'(timing.clear_pulse);
         end
         PH_CLR_LO: begin
            pins.clr = 1'b0;
            dur = TICK_W'(timing.clear_pulse);
         end
         PH_L_SETUP: begin
            pins.data = 1'b0;
            pins.clk = 1'b0;
            pins.latch[latch_chan] = 1'b0;
            dur = TICK_W'(timing.latch_setup);
         end
         PH_S_CLKLOW, PH_CK_LO, PH_CK_LO2: begin
            pins.clk = 1'b0;
            dur = TICK_W'(timing.clock_half);
         end
         PH_CK_HI: begin
            pins.clk = 1'b1;
            dur = TICK_W'(timing.clock_half);
         end
         PH_S_DATA: begin
            pins.data = shift_mask[shift_bit[3:0]];
            dur = TICK_W'(timing.data_setup);
         end
         PH_S_DATA_END: begin
            pins.data = 1'b0;
            dur = TICK_W'(timing.data_setup);
         end
         PH_L_PRE: dur = TICK_W'(timing.latch_setup);
         PH_L_LOW, PH_L_LOW2: begin
            pins.latch[latch_chan] = 1'b0;
            dur = TICK_W'(timing.latch_setup);
         end
         PH_L_HIGH: begin
            pins.latch[latch_chan] = 1'b1;
            dur = TICK_W'(timing.latch_pulse);
         end
         PH_BREAK: dur = timing.break_make;
         default: ;
      endcase
      // a zero count still lasts one tick
      if (dur == '0) dur = TICK_W'(1);
      ticks_left = dur - 1'b1;
   endfunction

   function automatic void start_latch(logic [2:0] ch, logic [MASK_W-1:0] m);
      latch_chan = ch;
      shift_mask = m;
      enter_seg(PH_L_SETUP);
   endfunction

   function automatic void close_seq();
      seq_phase = PH_IDLE;
      seq_kind = KIND_NONE;
      ticks_left = '0;
      pins = PINS_IDLE;
      seq_done = 1'b1;
   endfunction

   // one tick of the sequencer, returns the response it produces
   function automatic rsp_type tick_sequencer(req_type r);
      rsp_type    o;
      logic [2:0] err;
      o = '0;
      err = ERR_OK;
      seq_done = 1'b0;
      if (seq_phase != PH_IDLE) begin
         // running: commands are turned away, the sequence goes on
         if (r.action != ACT_TICK) err = ERR_BUSY;
         if (ticks_left > 0) begin
            ticks_left--;
         end else begin
            case (seq_phase)
               PH_INIT_IDLE: enter_seg(PH_CLR_HI1);
               PH_CLR_HI1: enter_seg(PH_CLR_LO);
               PH_CLR_LO: enter_seg(PH_CLR_HI2);
               PH_CLR_HI2: begin
                  if (seq_kind == KIND_FORCE) begin
                     start_latch(3'd0, '0);
                  end else begin
                     is_ready = 1'b1;
                     close_seq();
                  end
               end
               PH_L_SETUP: enter_seg(PH_S_CLKLOW);
               PH_S_CLKLOW: begin
                  shift_bit = 0;
                  enter_seg(PH_S_DATA);
               end
               PH_S_DATA: enter_seg(PH_CK_LO);
               PH_CK_LO: enter_seg(PH_CK_HI);
               PH_CK_HI: enter_seg(PH_CK_LO2);
               PH_CK_LO2: begin
                  shift_bit++;
                  if (shift_bit < MASK_BITS_DEF) enter_seg(PH_S_DATA);
                  else enter_seg(PH_S_DATA_END);
               end
               PH_S_DATA_END: enter_seg(PH_L_PRE);
               PH_L_PRE: enter_seg(PH_L_LOW);
               PH_L_LOW: enter_seg(PH_L_HIGH);
               PH_L_HIGH: enter_seg(PH_L_LOW2);
               PH_L_LOW2: begin
                  // latch pulse over, record the channel
                  chan_mask[latch_chan] = shift_mask;
                  if (seq_kind == KIND_APPLY_OFF) begin
                     if (timing.break_make != '0) begin
                        enter_seg(PH_BREAK);
                     end else begin
                        seq_kind = KIND_APPLY_ON;
                        start_latch(latch_chan, next_mask);
                     end
                  end else if (seq_kind == KIND_APPLY_ON) begin
                     chan_count[latch_chan]++;
                     is_safe = 1'b1;
                     close_seq();
                  end else if (seq_kind == KIND_FORCE && int'(latch_chan) + 1 < CHANNELS_DEF) begin
                     start_latch(latch_chan + 3'd1, '0);
                  end else begin
                     is_safe = 1'b1;
                     close_seq();
                  end
               end
               PH_BREAK: begin
                  seq_kind = KIND_APPLY_ON;
                  start_latch(latch_chan, next_mask);
               end
               default: close_seq();
            endcase
         end
      end else if (r.action == ACT_INIT) begin
         seq_kind = KIND_INIT;
         enter_seg(PH_INIT_IDLE);
      end else if (r.action == ACT_APPLY) begin
         // checks in order: ready, safe state, channel
         if (!is_ready) begin
            err = ERR_NOT_READY;
         end else if (r.safe_state_active) begin
            err = ERR_SAFE;
         end else if (r.channel >= CHANNELS_DEF) begin
            err = ERR_CHANNEL;
         end else begin
            is_safe = 1'b0;
            seq_kind = KIND_APPLY_OFF;
            next_mask = r.mask;
            start_latch(r.channel[2:0], '0);
         end
      end else if (r.action == ACT_FORCE) begin
         is_safe = 1'b0;
         if (!is_ready) begin
            err = ERR_NOT_READY;
         end else begin
            seq_kind = KIND_FORCE;
            pins.data = 1'b0;
            pins.clk = 1'b0;
            enter_seg(PH_CLR_HI1);
         end
      end

      o.serial_data = pins.data;
      o.shift_clock = pins.clk;
      o.clear_n = pins.clr;
      o.latch_lines = pins.latch;
      o.busy_res = (seq_phase != PH_IDLE);
      o.done_res = seq_done;
      o.error_code = err;
      o.outputs_safe = is_safe;
      if (r.channel < CHANNELS_DEF) begin
         o.readback_mask = chan_mask[r.channel[2:0]];
         o.readback_count = chan_count[r.channel[2:0]];
      end
      return o;
   endfunction

   function automatic req_type make_req(logic [1:0] a, logic [7:0] ch, logic [15:0] m,
                                        logic s);
      req_type r;
      r.action = a;
      r.channel = ch;
      r.mask = m;
      r.safe_state_active = s;
      return r;
   endfunction

   // mostly valid channels and the first bad one, sometimes anything
   function automatic logic [7:0] rand_chan();
      return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8));
   endfunction

   function automatic logic [15:0] rand_mask();
      logic [15:0] m;
      case ($urandom_range(7))
         0: m = 16'h0000;
         1: m = 16'hffff;
         default: m = 16'($urandom);
      endcase
      return m;
   endfunction

   // tick sent while a sequence runs, now and then a command that is turned away
   function automatic req_type filler_req();
      logic [1:0] a;
      a = ($urandom_range(15) == 0) ? 2'($urandom_range(3, 1)) : ACT_TICK;
      return make_req(a, rand_chan(), 16'($urandom), 1'($urandom));
   endfunction

   // forecast a tick and queue it for the driver
   task automatic queue_tick(req_type r);
      tick_item_type item;
      logic          was_idle;
      while (queued_ticks.size() >= 4) @(negedge clock);
      was_idle = (seq_phase == PH_IDLE);
      item.req = r;
      item.rsp = tick_sequencer(r);
      if (was_idle && item.rsp.busy_res) seq_started++;
      if (item.rsp.error_code != ERR_OK) turned_away++;
      ticks_sent++;
      // step through the idling phases as the run goes on
      idle_mode = (ticks_sent / 240) % 4;
      queued_ticks.push_back(item);
   endtask

   // keep ticking until the running sequence has ended
   task automatic run_out();
      while (seq_phase != PH_IDLE) queue_tick(filler_req());
   endtask

   task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CFG_CLOCK_HALF: timing.clock_half = v[7:0];
         CFG_DATA_SETUP: timing.data_setup = v[7:0];
         CFG_LATCH_SETUP: timing.latch_setup = v[7:0];
         CFG_LATCH_PULSE: timing.latch_pulse = v[7:0];
         CFG_CLEAR_PULSE: timing.clear_pulse = v[7:0];
         CFG_BREAK_MAKE: timing.break_make = v[TICK_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // new timing, written once every transfer has drained
   task automatic set_timing(cfg_type t, logic spare);
      while (queued_ticks.size() != 0 || req_valid || pin_forecast.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
      // upper data bits of the byte registers are don't-care
      write_reg(CFG_CLOCK_HALF, {12'($urandom), t.clock_half});
      write_reg(CFG_DATA_SETUP, {12'($urandom), t.data_setup});
      write_reg(CFG_LATCH_SETUP, {12'($urandom), t.latch_setup});
      write_reg(CFG_LATCH_PULSE, {12'($urandom), t.latch_pulse});
      write_reg(CFG_CLEAR_PULSE, {12'($urandom), t.clear_pulse});
      write_reg(CFG_BREAK_MAKE, t.break_make);
      if (spare) begin
         write_reg(CFG_SPARE_LO, 20'($urandom));
         write_reg(CFG_SPARE_HI, 20'($urandom));
      end
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   // request driver: valid holds until the transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) pin_forecast.push_back(held_forecast);
         if (!req_valid || req_ready) begin
            if (queued_ticks.size() != 0 &&
                $urandom_range(99) >= (idle_mode == 1 ? 75 : idle_mode == 3 ? 21 : 0)) begin
               next_item = queued_ticks.pop_front();
               req_valid <= 1'b1;
               req_data <= next_item.req;
               held_forecast <= next_item.rsp;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
      if (got !== exp_val) begin
         failures++;
         if (failures <= 10)
            $display("response %0d: %s expected %0h, got %0h", rsp_count, name, exp_val, got);
      end
   endtask

   // response monitor with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pin_forecast.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("response %0d: transfer with no tick outstanding", rsp_count);
            end else begin
               want = pin_forecast.pop_front();
               check_field("serial_data", 32'(rsp_data.serial_data), 32'(want.serial_data));
               check_field("shift_clock", 32'(rsp_data.shift_clock), 32'(want.shift_clock));
               check_field("clear_n", 32'(rsp_data.clear_n), 32'(want.clear_n));
               check_field("latch_lines", 32'(rsp_data.latch_lines), 32'(want.latch_lines));
               check_field("busy_res", 32'(rsp_data.busy_res), 32'(want.busy_res));
               check_field("done_res", 32'(rsp_data.done_res), 32'(want.done_res));
               check_field("error_code", 32'(rsp_data.error_code), 32'(want.error_code));
               check_field("outputs_safe", 32'(rsp_data.outputs_safe),
                           32'(want.outputs_safe));
               check_field("readback_mask", 32'(rsp_data.readback_mask),
                           32'(want.readback_mask));
               check_field("readback_count", rsp_data.readback_count, want.readback_count);
            end
            rsp_count++;
         end
         rsp_ready <= ($urandom_range(99) >=
                       (idle_mode == 2 ? 75 : idle_mode == 3 ? 21 : 0));
      end
   end

   // stimulus
   initial begin
      int spin;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // before init: not ready, and a readback beyond the last channel
      queue_tick(make_req(ACT_TICK, 8'h00, 16'h0000, 1'b0));
      queue_tick(make_req(ACT_APPLY, 8'h00, 16'hffff, 1'b0));
      queue_tick(make_req(ACT_FORCE, 8'h01, 16'h0000, 1'b1));
      queue_tick(make_req(ACT_TICK, 8'hff, 16'hffff, 1'b1));
      queue_tick(make_req(ACT_INIT, 8'h02, 16'h1234, 1'b0));
      // every command is turned away while init runs
      queue_tick(make_req(ACT_APPLY, 8'h02, 16'h00ff, 1'b0));
      queue_tick(make_req(ACT_FORCE, 8'h02, 16'h0000, 1'b0));
      queue_tick(make_req(ACT_INIT, 8'h02, 16'h0000, 1'b0));
      run_out();
      // rejected applies: safe state, bad channel, safe state ahead of channel
      queue_tick(make_req(ACT_APPLY, 8'h01, 16'h5555, 1'b1));
      queue_tick(make_req(ACT_APPLY, 8'h08, 16'h5555, 1'b0));
      queue_tick(make_req(ACT_APPLY, 8'hff, 16'h5555, 1'b0));
      queue_tick(make_req(ACT_APPLY, 8'hff, 16'h5555, 1'b1));

      // zero timings count as one tick, zero break skips the wait
      set_timing('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 20'd0}, 1'b1);
      queue_tick(make_req(ACT_APPLY, 8'h07, 16'hffff, 1'b0));
      run_out();
      queue_tick(make_req(ACT_TICK, 8'h07, 16'h0000, 1'b0));

      // short break between the off latch and the new mask
      set_timing('{8'd1, 8'd0, 8'd1, 8'd0, 8'd1, 20'd3}, 1'b0);
      queue_tick(make_req(ACT_APPLY, 8'h00, rand_mask(), 1'b0));
      run_out();

      // force-off latches zero into every channel
      queue_tick(make_req(ACT_FORCE, 8'h07, 16'hffff, 1'b0));
      run_out();
      queue_tick(make_req(ACT_TICK, 8'h00, 16'h0000, 1'b0));

      // wait for every tick to go out and its response to come back
      while (queued_ticks.size() != 0 || req_valid) @(negedge clock);
      spin = 0;
      while (pin_forecast.size() != 0 && spin < 2000) begin
         @(negedge clock);
         spin++;
      end
      repeat (10) @(posedge clock);
      failures += pin_forecast.size();

      $display("covered %0d ticks: %0d sequences started, %0d commands turned away",
               ticks_sent, seq_started, turned_away);
      $display("%0d register writes over %0d timing settings, %0d responses checked",
               reg_writes, settings_used, rsp_count);
      if (failures == 0) begin
         $display("shift_latch_channel_driver_core_test passed");
      end else begin
         $display("shift_latch_channel_driver_core_test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("shift_latch_channel_driver_core_test failed");
      $finish;
   end

endmodule
